FILE: hw/rtl/ttl_pkg.sv
// ----------------------------------------------------------------------------
// ttl_pkg: shared types and constants of the text token lexer
// Character codes, character classes and the beat and queue entry layout.
// ----------------------------------------------------------------------------
package ttl_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_BEATS   = 4;
    localparam int SLOT_W      = $clog2(MAX_BEATS);

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDERLINE = 8'h5F;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_POINT     = 8'h2E;
    localparam logic [7:0] CH_EXP       = 8'h65;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;

    // One result beat
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       token_end;
    } beat_t;

    // All beats caused by one input item
    typedef struct packed {
        logic [SLOT_W-1:0]           last_idx;
        beat_t [MAX_BEATS-1:0]       beats;
    } entry_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic beat_t char_beat(input logic [7:0] c);
        beat_t b;
        b.out_char   = c;
        b.char_valid = 1'b1;
        b.token_end  = 1'b0;
        return b;
    endfunction

    function automatic beat_t end_beat();
        beat_t b;
        b.out_char   = 8'h00;
        b.char_valid = 1'b0;
        b.token_end  = 1'b1;
        return b;
    endfunction

endpackage

FILE: hw/rtl/ttl_front.sv
// ----------------------------------------------------------------------------
// ttl_front: character classifier and scanner state
// Takes one character per beat, advances the scanner and packs every result
// beat that the character causes into one queue entry.
// ----------------------------------------------------------------------------
module ttl_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_char_code,
    input  logic            s_end_of_input,
    input  logic            q_full,
    output logic            q_push,
    output ttl_pkg::entry_t q_data
);

    typedef enum logic [3:0] {
        ST_PREFIX  = 4'd0,
        ST_ALNUM   = 4'd1,
        ST_SIGN    = 4'd2,
        ST_INT     = 4'd3,
        ST_POINT   = 4'd4,
        ST_FIXED   = 4'd5,
        ST_EXP     = 4'd6,
        ST_EXPSIGN = 4'd7,
        ST_EXPINT  = 4'd8,
        ST_LQUOTE  = 4'd9,
        ST_STRING  = 4'd10,
        ST_ESCAPE  = 4'd11,
        ST_RQUOTE  = 4'd12,
        ST_SYMBOL  = 4'd13
    } lex_state_t;

    lex_state_t state_reg, state_next;
    logic       comment_reg, comment_next;
    logic       accept;
    logic       done;
    logic [2:0] n;
    logic [7:0] c;
    ttl_pkg::beat_t [ttl_pkg::MAX_BEATS-1:0] beats;

    assign c       = s_char_code;
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Scan one character: next state and the beats it causes
    always_comb begin
        beats        = '0;
        n            = 3'd0;
        done         = 1'b0;
        state_next   = state_reg;
        comment_next = comment_reg;

        if (s_end_of_input) begin
            comment_next = 1'b0;
            state_next   = ST_PREFIX;
            if ((state_reg != ST_PREFIX) && (state_reg <= ST_SYMBOL)) begin
                done = 1'b1;
            end
        end else if (comment_reg) begin
            if (c == ttl_pkg::CH_RBRACE) begin
                comment_next = 1'b0;
            end
        end else if ((c == ttl_pkg::CH_LBRACE) && (state_reg != ST_ESCAPE)) begin
            comment_next = 1'b1;
        end else begin
            unique case (state_reg)
                ST_ALNUM: begin
                    if (ttl_pkg::is_alpha(c) || (c == ttl_pkg::CH_UNDERLINE) ||
                        ttl_pkg::is_digit(c)) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                    end else begin
                        done = 1'b1;
                    end
                end
                ST_SIGN: begin
                    if (ttl_pkg::is_digit(c)) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                        state_next = ST_INT;
                    end else if (c == ttl_pkg::CH_POINT) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(ttl_pkg::CH_ZERO); n = n + 3'd1;
                        beats[n[1:0]] = ttl_pkg::char_beat(ttl_pkg::CH_POINT); n = n + 3'd1;
                        state_next = ST_POINT;
                    end else begin
                        done = 1'b1;
                    end
                end
                ST_INT: begin
                    if (ttl_pkg::is_digit(c)) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                    end else if (c == ttl_pkg::CH_POINT) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                        state_next = ST_POINT;
                    end else begin
                        done = 1'b1;
                    end
                end
                ST_POINT: begin
                    if (ttl_pkg::is_digit(c)) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                        state_next = ST_FIXED;
                    end else if (c == ttl_pkg::CH_EXP) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(ttl_pkg::CH_ZERO); n = n + 3'd1;
                        beats[n[1:0]] = ttl_pkg::char_beat(ttl_pkg::CH_EXP); n = n + 3'd1;
                        state_next = ST_EXP;
                    end else begin
                        done = 1'b1;
                    end
                end
                ST_FIXED: begin
                    if (ttl_pkg::is_digit(c)) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                    end else if (c == ttl_pkg::CH_EXP) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                        state_next = ST_EXP;
                    end else begin
                        done = 1'b1;
                    end
                end
                ST_EXP: begin
                    if ((c == ttl_pkg::CH_PLUS) || (c == ttl_pkg::CH_MINUS)) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                        state_next = ST_EXPSIGN;
                    end else if (ttl_pkg::is_digit(c)) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                        state_next = ST_EXPINT;
                    end else begin
                        done = 1'b1;
                    end
                end
                ST_EXPSIGN: begin
                    if (ttl_pkg::is_digit(c)) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                        state_next = ST_EXPINT;
                    end else begin
                        done = 1'b1;
                    end
                end
                ST_EXPINT: begin
                    if (ttl_pkg::is_digit(c)) begin
                        beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                    end else begin
                        done = 1'b1;
                    end
                end
                ST_LQUOTE, ST_STRING: begin
                    if (c == ttl_pkg::CH_BACKSLASH) begin
                        state_next = ST_ESCAPE;
                    end else if (c == ttl_pkg::CH_QUOTE) begin
                        state_next = ST_RQUOTE;
                    end else begin
                        beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                        state_next = ST_STRING;
                    end
                end
                ST_ESCAPE: begin
                    beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                    state_next = ST_STRING;
                end
                ST_RQUOTE, ST_SYMBOL: begin
                    done = 1'b1;
                end
                default: ;
            endcase
        end

        // Close the open token: pad a missing digit, then the token end
        if (done) begin
            if ((state_reg == ST_POINT) || (state_reg == ST_EXP) ||
                (state_reg == ST_EXPSIGN)) begin
                beats[n[1:0]] = ttl_pkg::char_beat(ttl_pkg::CH_ZERO); n = n + 3'd1;
            end
            beats[n[1:0]] = ttl_pkg::end_beat(); n = n + 3'd1;
            state_next = ST_PREFIX;
        end

        // Start a token: from prefix state, or reprocess the ending character
        if (!s_end_of_input && !comment_reg &&
            !((c == ttl_pkg::CH_LBRACE) && (state_reg != ST_ESCAPE)) &&
            (done || (state_reg == ST_PREFIX) || (state_reg > ST_SYMBOL))) begin
            priority if (ttl_pkg::is_alpha(c) || (c == ttl_pkg::CH_UNDERLINE)) begin
                beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                state_next = ST_ALNUM;
            end else if ((c == ttl_pkg::CH_PLUS) || (c == ttl_pkg::CH_MINUS)) begin
                beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                state_next = ST_SIGN;
            end else if (ttl_pkg::is_digit(c)) begin
                beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                state_next = ST_INT;
            end else if (c == ttl_pkg::CH_POINT) begin
                beats[n[1:0]] = ttl_pkg::char_beat(ttl_pkg::CH_ZERO); n = n + 3'd1;
                beats[n[1:0]] = ttl_pkg::char_beat(ttl_pkg::CH_POINT); n = n + 3'd1;
                state_next = ST_POINT;
            end else if (c == ttl_pkg::CH_QUOTE) begin
                state_next = ST_LQUOTE;
            end else if (ttl_pkg::is_space(c)) begin
                state_next = ST_PREFIX;
            end else begin
                beats[n[1:0]] = ttl_pkg::char_beat(c); n = n + 3'd1;
                state_next = ST_SYMBOL;
            end
        end
    end

    // Hand the packed beats to the queue
    assign q_push         = accept && (n != 3'd0);
    assign q_data.beats    = beats;
    assign q_data.last_idx = ttl_pkg::SLOT_W'(n - 3'd1);

    // Hold scanner state, advance on an accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_PREFIX;
            comment_reg <= 1'b0;
        end else if (accept) begin
            state_reg   <= state_next;
            comment_reg <= comment_next;
        end
    end

endmodule

FILE: hw/rtl/ttl_queue.sv
// ----------------------------------------------------------------------------
// ttl_queue: entry queue between scanner and beat serializer
// Small circular buffer of packed result entries.
// ----------------------------------------------------------------------------
module ttl_queue #(
    parameter int QueueDepth = ttl_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ttl_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output ttl_pkg::entry_t head
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    ttl_pkg::entry_t mem [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign full    = (count_reg == CntW'(QueueDepth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // Write entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/ttl_back.sv
// ----------------------------------------------------------------------------
// ttl_back: result beat serializer
// Walks the head entry slot by slot into the registered result channel and
// marks the final beat of each entry.
// ----------------------------------------------------------------------------
module ttl_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  ttl_pkg::entry_t q_head,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_char,
    output logic            m_char_valid,
    output logic            m_token_end,
    output logic            m_last
);

    logic [ttl_pkg::SLOT_W-1:0] idx_reg;
    logic                       valid_reg;
    ttl_pkg::beat_t             beat_reg;
    logic                       last_reg;
    logic                       load;
    logic                       is_last;

    assign load    = (!valid_reg || m_ready) && !q_empty;
    assign is_last = (idx_reg == q_head.last_idx);
    assign q_pop   = load && is_last;

    // Hold output beat; load next slot when the register frees up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? '0 : idx_reg + 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= q_head.beats[idx_reg];
            last_reg <= is_last;
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_char   = beat_reg.out_char;
    assign m_char_valid = beat_reg.char_valid;
    assign m_token_end  = beat_reg.token_end;
    assign m_last       = last_reg;

endmodule

FILE: hw/rtl/text_token_lexer.sv
// ----------------------------------------------------------------------------
// text_token_lexer: streaming tokenizer over an ASCII character stream
// Splits characters into identifier, number, string and symbol tokens, with
// number normalization, brace comments dropped and whitespace skipped.
//
//   Channel | Direction | Payload                                      | Beat
//   s_      | in        | char_code[7:0], end_of_input                 | one character
//   m_      | out       | out_char[7:0], char_valid, token_end, last   | one result
//
// The scanner takes one character per cycle unless the queue is full, and packs
// its zero to four results into one queue entry; the serializer sends one result
// per cycle while m_ready is high. The sustained rate is one character per cycle
// while each character yields at most one result and m_ready stays high.
// aresetn (synchronous, active low) empties the queue and resets the scanner.
// s_ready drops only while the entry queue is full; m_ stalls back up there.
// ----------------------------------------------------------------------------
module text_token_lexer #(
    parameter int QueueDepth = ttl_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_char_valid,
    output logic       m_token_end,
    output logic       m_last
);

    logic            q_push, q_full, q_pop, q_empty;
    ttl_pkg::entry_t q_data, q_head;

    ttl_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_end_of_input (s_end_of_input),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_data)
    );

    ttl_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    ttl_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_char_valid (m_char_valid),
        .m_token_end  (m_token_end),
        .m_last       (m_last)
    );

endmodule
